// File: design/clps_pkg.sv
// Shared constants and state encoding for the closed-loop polyline simplifier.
package clps_pkg;

  localparam int CFG_W     = 16;
  localparam int SRC_IDX_W = 6;

  typedef enum logic [34:0] {
    S_LOAD      = 35'b1 << 0,
    S_START     = 35'b1 << 1,
    S_ANC_RD    = 35'b1 << 2,
    S_ANC_CMP   = 35'b1 << 3,
    S_FAR_RD    = 35'b1 << 4,
    S_FAR_DIF   = 35'b1 << 5,
    S_FAR_MX    = 35'b1 << 6,
    S_FAR_MY    = 35'b1 << 7,
    S_FAR_CMP   = 35'b1 << 8,
    S_SETUP     = 35'b1 << 9,
    S_CHAIN     = 35'b1 << 10,
    S_POP       = 35'b1 << 11,
    S_SPAN_LD   = 35'b1 << 12,
    S_RDA       = 35'b1 << 13,
    S_RDB       = 35'b1 << 14,
    S_DEN_X     = 35'b1 << 15,
    S_DEN_Y     = 35'b1 << 16,
    S_BEST      = 35'b1 << 17,
    S_K_RD      = 35'b1 << 18,
    S_K_DIF     = 35'b1 << 19,
    S_DOT_X     = 35'b1 << 20,
    S_DOT_Y     = 35'b1 << 21,
    S_SEL       = 35'b1 << 22,
    S_SQ_X      = 35'b1 << 23,
    S_SQ_Y      = 35'b1 << 24,
    S_CR_X      = 35'b1 << 25,
    S_CR_Y      = 35'b1 << 26,
    S_M01       = 35'b1 << 27,
    S_ML        = 35'b1 << 28,
    S_MR        = 35'b1 << 29,
    S_SPLIT     = 35'b1 << 30,
    S_PUSH2     = 35'b1 << 31,
    S_EMIT_SCAN = 35'b1 << 32,
    S_EMIT_PUT  = 35'b1 << 33,
    S_DONE      = 35'b1 << 34
  } state_t;

endpackage

// File: design/clps_in_if.sv
// Vertex input channel interface.
interface clps_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         end_of_loop;

  modport source(output valid, point_x, point_y, end_of_loop, input ready);
  modport sink(input valid, point_x, point_y, end_of_loop, output ready);
endinterface

// File: design/clps_out_if.sv
// Kept-vertex output channel interface.
interface clps_out_if #(parameter int COORD_BITS = 16);
  import clps_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] kept_x;
  logic signed [COORD_BITS-1:0] kept_y;
  logic [SRC_IDX_W-1:0]         source_index;
  logic                         passed_unchanged;
  logic                         overflow;
  logic                         final_vertex;

  modport source(output valid, kept_x, kept_y, source_index, passed_unchanged, overflow,
                 final_vertex, input ready);
  modport sink(input valid, kept_x, kept_y, source_index, passed_unchanged, overflow,
               final_vertex, output ready);
endinterface

// File: design/clps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: design/clps_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module clps_serial_mul #(
  parameter int AW = 68,
  parameter int BW = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] p
);
  localparam int PRW = AW + BW;
  localparam int CW  = $clog2(BW);

  logic [PRW-1:0] acc_r;
  logic [PRW-1:0] a_sh_r;
  logic [BW-1:0]  b_sh_r;
  logic [CW-1:0]  cnt_r;
  logic           run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (run_r && cnt_r == '0) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      a_sh_r <= PRW'(a);
      b_sh_r <= b;
      cnt_r  <= CW'(BW - 1);
    end else if (run_r) begin
      if (b_sh_r[0]) begin
        acc_r <= acc_r + a_sh_r;
      end
      a_sh_r <= a_sh_r << 1;
      b_sh_r <= b_sh_r >> 1;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign busy = run_r;
  assign p    = acc_r;
endmodule

// File: design/closed_loop_polyline_simplifier_unit.sv
// Closed-loop polygon simplifier: top level with sequencer and shared datapath.
//
// Input beats on in_ch carry one vertex each; the beat with end_of_loop set
// closes the polygon. Vertices load one per cycle into a vertex RAM; beats
// past MAX_VERTICES are dropped and flagged on every output beat of the run.
// After the closing beat in_ch.ready stays low while the block finds the
// anchor (read, compare per vertex), the far vertex (read, difference, squares,
// compare per vertex) and runs Douglas-Peucker on both chains. Each candidate
// vertex of a span is judged with the bit-serial multiplier, of width
// W = 2*COORD_BITS+2, that forms the exact three-factor distance products.
// Kept vertices then leave on out_ch, a scan stepping past skipped vertices,
// final_vertex on the last beat; a stalled receiver holds the sequencer until
// the beat is taken.
// A one-beat output register lets a stalled receiver hold the last beat while
// the next polygon loads.
// cfg_wr_en/cfg_wr_data write max_deviation; write it only while idle.
// Synchronous active-low reset clears control state and max_deviation; no
// clearing pass is needed.
module closed_loop_polyline_simplifier_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  clps_in_if.sink                     in_ch,
  clps_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [clps_pkg::CFG_W-1:0]  cfg_wr_data
);
  import clps_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int IDXW = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int PW   = IDXW + 1;
  localparam int D    = C + 1;
  localparam int W    = 2 * C + 2;
  localparam int MW   = 2 * W;
  localparam int LW   = 3 * W;

  state_t st_r, st_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt, pass_r, pass_nxt;
  logic [CFG_W-1:0] maxdev_r, maxdev_nxt;
  logic [IDXW-1:0] i_r, i_nxt, anc_r, anc_nxt, far_r, far_nxt, eidx_r, eidx_nxt;
  logic signed [C-1:0] ancx_r, ancx_nxt, ancy_r, ancy_nxt, farx_r, farx_nxt, fary_r, fary_nxt;
  logic signed [C-1:0] pvx_r, pvx_nxt, pvy_r, pvy_nxt, sax_r, sax_nxt, say_r, say_nxt;
  logic signed [C-1:0] sbx_r, sbx_nxt, sby_r, sby_nxt;
  logic [W-1:0] fard_r, fard_nxt, den_r, den_nxt, d2_r, d2_nxt, b2_r, b2_nxt;
  logic far_any_r, far_any_nxt, chain_r, chain_nxt, split_ok_r, split_ok_nxt;
  logic [MAX_VERTICES-1:0] mask_r, mask_nxt;
  logic [PW-1:0] kept_r, kept_nxt, seen_r, seen_nxt;
  logic [IDXW-1:0] sp_r, sp_nxt;
  logic [PW-1:0] f_r, f_nxt, l_r, l_nxt, k_r, k_nxt, split_r, split_nxt;
  logic signed [D-1:0] px_r, px_nxt, py_r, py_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [W-1:0] acc_r, acc_nxt, dot_r, dot_nxt;
  logic [MW-1:0] c01_r, c01_nxt, b01_r, b01_nxt;
  logic [LW-1:0] lprod_r, lprod_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [C-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [SRC_IDX_W-1:0] osrc_r, osrc_nxt;
  logic opass_r, opass_nxt, oovf_r, oovf_nxt, ofin_r, ofin_nxt;

  logic vwr_en, vrd_en, swr_en, srd_en;
  logic [IDXW-1:0] vrd_addr, swr_addr, srd_addr;
  logic [2*C-1:0] vrd_data;
  logic [2*PW-1:0] swr_data, srd_data;
  logic signed [C-1:0] vrd_x, vrd_y;
  logic [PW-1:0] srd_f, srd_l, n_pw, cs, ce;
  logic last_i;

  logic signed [D-1:0] ma, mb;
  logic signed [W-1:0] prod, acc_sum, acc_dif;
  logic [W-1:0] mag, dsq;
  logic [IDXW-1:0] eidx;

  logic mul_start, mul_busy;
  logic [MW-1:0] ml_a;
  logic [W-1:0] ml_b;
  logic [LW-1:0] mul_p;

  function automatic logic [IDXW-1:0] wrap_pos(input logic [PW-1:0] pos,
                                               input logic [PW-1:0] n);
    logic [PW-1:0] t;
    t = (pos >= n) ? pos - n : pos;
    return t[IDXW-1:0];
  endfunction

  function automatic logic lex_less(input logic signed [C-1:0] x0, input logic signed [C-1:0] y0,
                                    input logic signed [C-1:0] x1, input logic signed [C-1:0] y1);
    return (x0 != x1) ? (x0 < x1) : (y0 < y1);
  endfunction

  function automatic logic signed [D-1:0] sub_c(input logic signed [C-1:0] a,
                                                input logic signed [C-1:0] b);
    return {a[C-1], a} - {b[C-1], b};
  endfunction

  clps_ram #(.WIDTH(2 * C), .DEPTH(MAX_VERTICES)) u_vram (
    .clk(clk), .wr_en(vwr_en), .wr_addr(cnt_r[IDXW-1:0]),
    .wr_data({in_ch.point_x, in_ch.point_y}),
    .rd_en(vrd_en), .rd_addr(vrd_addr), .rd_data(vrd_data)
  );

  clps_ram #(.WIDTH(2 * PW), .DEPTH(MAX_VERTICES)) u_sram (
    .clk(clk), .wr_en(swr_en), .wr_addr(swr_addr), .wr_data(swr_data),
    .rd_en(srd_en), .rd_addr(srd_addr), .rd_data(srd_data)
  );

  clps_serial_mul #(.AW(MW), .BW(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(ml_a), .b(ml_b),
    .busy(mul_busy), .p(mul_p)
  );

  assign vrd_x   = vrd_data[2*C-1:C];
  assign vrd_y   = vrd_data[C-1:0];
  assign srd_f   = srd_data[2*PW-1:PW];
  assign srd_l   = srd_data[PW-1:0];
  assign n_pw    = PW'(cnt_r);
  assign last_i  = (PW'(i_r) == n_pw - 1'b1);
  assign prod    = ma * mb;
  assign acc_sum = acc_r + prod;
  assign acc_dif = acc_r - prod;
  assign mag     = acc_dif[W-1] ? W'(-acc_dif) : W'(acc_dif);
  assign dsq     = acc_r;
  assign eidx    = pass_r ? i_r : wrap_pos(PW'(anc_r) + PW'(i_r), n_pw);
  assign cs      = chain_r ? PW'(far_r) : PW'(anc_r);
  assign ce      = chain_r ? ((anc_r > far_r) ? PW'(anc_r) : PW'(anc_r) + n_pw)
                           : ((far_r > anc_r) ? PW'(far_r) : PW'(far_r) + n_pw);

  assign in_ch.ready             = (st_r == S_LOAD);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.kept_x           = ox_r;
  assign out_ch.kept_y           = oy_r;
  assign out_ch.source_index     = osrc_r;
  assign out_ch.passed_unchanged = opass_r;
  assign out_ch.overflow         = oovf_r;
  assign out_ch.final_vertex     = ofin_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; pass_nxt = pass_r;
    maxdev_nxt = maxdev_r; i_nxt = i_r; anc_nxt = anc_r; far_nxt = far_r; eidx_nxt = eidx_r;
    ancx_nxt = ancx_r; ancy_nxt = ancy_r; farx_nxt = farx_r; fary_nxt = fary_r;
    pvx_nxt = pvx_r; pvy_nxt = pvy_r; sax_nxt = sax_r; say_nxt = say_r;
    sbx_nxt = sbx_r; sby_nxt = sby_r; fard_nxt = fard_r; den_nxt = den_r;
    d2_nxt = d2_r; b2_nxt = b2_r; far_any_nxt = far_any_r; chain_nxt = chain_r;
    split_ok_nxt = split_ok_r; mask_nxt = mask_r; kept_nxt = kept_r; seen_nxt = seen_r;
    sp_nxt = sp_r; f_nxt = f_r; l_nxt = l_r; k_nxt = k_r; split_nxt = split_r;
    px_nxt = px_r; py_nxt = py_r; ex_nxt = ex_r; ey_nxt = ey_r;
    acc_nxt = acc_r; dot_nxt = dot_r; c01_nxt = c01_r; b01_nxt = b01_r; lprod_nxt = lprod_r;
    out_valid_nxt = out_valid_r; ox_nxt = ox_r; oy_nxt = oy_r; osrc_nxt = osrc_r;
    opass_nxt = opass_r; oovf_nxt = oovf_r; ofin_nxt = ofin_r;
    vwr_en = 1'b0; vrd_en = 1'b0; vrd_addr = '0;
    swr_en = 1'b0; swr_addr = '0; swr_data = '0; srd_en = 1'b0; srd_addr = '0;
    mul_start = 1'b0; ml_a = '0; ml_b = '0; ma = '0; mb = '0;

    if (cfg_wr_en) begin
      maxdev_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_LOAD: begin
        if (in_ch.valid) begin
          if (cnt_r != CNTW'(MAX_VERTICES)) begin
            vwr_en  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.end_of_loop) begin
            st_nxt = S_START;
          end
        end
      end
      S_START: begin
        i_nxt = '0;
        if (cnt_r <= CNTW'(3) || maxdev_r == '0) begin
          pass_nxt = 1'b1;
          st_nxt   = S_EMIT_SCAN;
        end else begin
          st_nxt = S_ANC_RD;
        end
      end
      S_ANC_RD: begin
        vrd_en = 1'b1; vrd_addr = i_r;
        st_nxt = S_ANC_CMP;
      end
      S_ANC_CMP: begin
        if (i_r == '0 || lex_less(vrd_x, vrd_y, ancx_r, ancy_r)) begin
          anc_nxt = i_r; ancx_nxt = vrd_x; ancy_nxt = vrd_y;
        end
        if (last_i) begin
          i_nxt = '0; far_any_nxt = 1'b0;
          st_nxt = S_FAR_RD;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = S_ANC_RD;
        end
      end
      S_FAR_RD: begin
        vrd_en = 1'b1; vrd_addr = i_r;
        st_nxt = S_FAR_DIF;
      end
      S_FAR_DIF: begin
        pvx_nxt = vrd_x; pvy_nxt = vrd_y;
        px_nxt = sub_c(vrd_x, ancx_r); py_nxt = sub_c(vrd_y, ancy_r);
        st_nxt = S_FAR_MX;
      end
      S_FAR_MX: begin
        ma = px_r; mb = px_r; acc_nxt = prod;
        st_nxt = S_FAR_MY;
      end
      S_FAR_MY: begin
        ma = py_r; mb = py_r; acc_nxt = acc_sum;
        st_nxt = S_FAR_CMP;
      end
      S_FAR_CMP: begin
        if (!far_any_r || dsq > fard_r ||
            (dsq == fard_r && lex_less(pvx_r, pvy_r, farx_r, fary_r))) begin
          far_nxt = i_r; farx_nxt = pvx_r; fary_nxt = pvy_r; fard_nxt = dsq;
        end
        far_any_nxt = 1'b1;
        if (last_i) begin
          st_nxt = S_SETUP;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = S_FAR_RD;
        end
      end
      S_SETUP: begin
        i_nxt = '0;
        if (far_r == anc_r) begin
          pass_nxt = 1'b1;
          st_nxt   = S_EMIT_SCAN;
        end else begin
          mask_nxt = '0;
          mask_nxt[anc_r] = 1'b1;
          mask_nxt[far_r] = 1'b1;
          kept_nxt = PW'(2); chain_nxt = 1'b0; sp_nxt = '0;
          st_nxt = S_CHAIN;
        end
      end
      S_CHAIN: begin
        if (ce >= cs + PW'(2)) begin
          swr_en = 1'b1; swr_addr = '0; swr_data = {cs, ce};
          sp_nxt = IDXW'(1);
        end
        st_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          if (!chain_r) begin
            chain_nxt = 1'b1;
            st_nxt = S_CHAIN;
          end else begin
            i_nxt = '0; seen_nxt = '0;
            if (kept_r < PW'(3)) begin
              pass_nxt = 1'b1;
            end
            st_nxt = S_EMIT_SCAN;
          end
        end else begin
          srd_en = 1'b1; srd_addr = sp_r - 1'b1;
          sp_nxt = sp_r - 1'b1;
          st_nxt = S_SPAN_LD;
        end
      end
      S_SPAN_LD: begin
        f_nxt = srd_f; l_nxt = srd_l;
        vrd_en = 1'b1; vrd_addr = wrap_pos(srd_f, n_pw);
        st_nxt = S_RDA;
      end
      S_RDA: begin
        sax_nxt = vrd_x; say_nxt = vrd_y;
        vrd_en = 1'b1; vrd_addr = wrap_pos(l_r, n_pw);
        st_nxt = S_RDB;
      end
      S_RDB: begin
        sbx_nxt = vrd_x; sby_nxt = vrd_y;
        ex_nxt = sub_c(vrd_x, sax_r); ey_nxt = sub_c(vrd_y, say_r);
        st_nxt = S_DEN_X;
      end
      S_DEN_X: begin
        ma = ex_r; mb = ex_r; acc_nxt = prod;
        st_nxt = S_DEN_Y;
      end
      S_DEN_Y: begin
        ma = ey_r; mb = ey_r; den_nxt = acc_sum;
        mul_start = 1'b1; ml_a = MW'(maxdev_r); ml_b = W'(maxdev_r);
        st_nxt = S_BEST;
      end
      S_BEST: begin
        if (!mul_busy) begin
          b01_nxt = mul_p[MW-1:0]; b2_nxt = W'(1); split_ok_nxt = 1'b0;
          k_nxt = f_r + 1'b1;
          st_nxt = S_K_RD;
        end
      end
      S_K_RD: begin
        if (k_r == l_r) begin
          st_nxt = S_SPLIT;
        end else begin
          vrd_en = 1'b1; vrd_addr = wrap_pos(k_r, n_pw);
          st_nxt = S_K_DIF;
        end
      end
      S_K_DIF: begin
        pvx_nxt = vrd_x; pvy_nxt = vrd_y;
        px_nxt = sub_c(vrd_x, sax_r); py_nxt = sub_c(vrd_y, say_r);
        st_nxt = S_DOT_X;
      end
      S_DOT_X: begin
        ma = px_r; mb = ex_r; acc_nxt = prod;
        st_nxt = S_DOT_Y;
      end
      S_DOT_Y: begin
        ma = py_r; mb = ey_r; dot_nxt = acc_sum;
        st_nxt = S_SEL;
      end
      S_SEL: begin
        if (den_r == '0 || dot_r[W-1] || dot_r == '0) begin
          d2_nxt = W'(1);
          st_nxt = S_SQ_X;
        end else if (W'(dot_r) >= den_r) begin
          px_nxt = sub_c(pvx_r, sbx_r); py_nxt = sub_c(pvy_r, sby_r);
          d2_nxt = W'(1);
          st_nxt = S_SQ_X;
        end else begin
          d2_nxt = den_r;
          st_nxt = S_CR_X;
        end
      end
      S_SQ_X: begin
        ma = px_r; mb = px_r; acc_nxt = prod;
        st_nxt = S_SQ_Y;
      end
      S_SQ_Y: begin
        ma = py_r; mb = py_r;
        mul_start = 1'b1; ml_a = MW'(W'(acc_sum)); ml_b = W'(1);
        st_nxt = S_M01;
      end
      S_CR_X: begin
        ma = px_r; mb = ey_r; acc_nxt = prod;
        st_nxt = S_CR_Y;
      end
      S_CR_Y: begin
        ma = py_r; mb = ex_r;
        mul_start = 1'b1; ml_a = MW'(mag); ml_b = mag;
        st_nxt = S_M01;
      end
      S_M01: begin
        if (!mul_busy) begin
          c01_nxt = mul_p[MW-1:0];
          mul_start = 1'b1; ml_a = mul_p[MW-1:0]; ml_b = b2_r;
          st_nxt = S_ML;
        end
      end
      S_ML: begin
        if (!mul_busy) begin
          lprod_nxt = mul_p;
          mul_start = 1'b1; ml_a = b01_r; ml_b = d2_r;
          st_nxt = S_MR;
        end
      end
      S_MR: begin
        if (!mul_busy) begin
          if (lprod_r > mul_p) begin
            b01_nxt = c01_r; b2_nxt = d2_r; split_nxt = k_r; split_ok_nxt = 1'b1;
          end
          k_nxt = k_r + 1'b1;
          st_nxt = S_K_RD;
        end
      end
      S_SPLIT: begin
        if (!split_ok_r) begin
          st_nxt = S_POP;
        end else begin
          mask_nxt[wrap_pos(split_r, n_pw)] = 1'b1;
          kept_nxt = kept_r + 1'b1;
          if (l_r >= split_r + PW'(2)) begin
            swr_en = 1'b1; swr_addr = sp_r; swr_data = {split_r, l_r};
            sp_nxt = sp_r + 1'b1;
          end
          st_nxt = S_PUSH2;
        end
      end
      S_PUSH2: begin
        if (split_r >= f_r + PW'(2)) begin
          swr_en = 1'b1; swr_addr = sp_r; swr_data = {f_r, split_r};
          sp_nxt = sp_r + 1'b1;
        end
        st_nxt = S_POP;
      end
      S_EMIT_SCAN: begin
        if (pass_r || mask_r[eidx]) begin
          vrd_en = 1'b1; vrd_addr = eidx; eidx_nxt = eidx;
          st_nxt = S_EMIT_PUT;
        end else if (last_i) begin
          st_nxt = S_DONE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_EMIT_PUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          ox_nxt = vrd_x; oy_nxt = vrd_y;
          osrc_nxt = SRC_IDX_W'(eidx_r);
          opass_nxt = pass_r; oovf_nxt = ovf_r;
          ofin_nxt = pass_r ? last_i : (seen_r + 1'b1 == kept_r);
          seen_nxt = seen_r + 1'b1;
          if (last_i) begin
            st_nxt = S_DONE;
          end else begin
            i_nxt = i_r + 1'b1;
            st_nxt = S_EMIT_SCAN;
          end
        end
      end
      S_DONE: begin
        cnt_nxt = '0; mask_nxt = '0; ovf_nxt = 1'b0; pass_nxt = 1'b0;
        st_nxt = S_LOAD;
      end
      default: begin
        st_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; pass_r <= 1'b0; maxdev_r <= '0;
      mask_r <= '0; kept_r <= '0; seen_r <= '0; sp_r <= '0; chain_r <= 1'b0;
      far_any_r <= 1'b0; split_ok_r <= 1'b0; out_valid_r <= 1'b0;
      anc_r <= '0; far_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; pass_r <= pass_nxt;
      maxdev_r <= maxdev_nxt; mask_r <= mask_nxt; kept_r <= kept_nxt; seen_r <= seen_nxt;
      sp_r <= sp_nxt; chain_r <= chain_nxt; far_any_r <= far_any_nxt;
      split_ok_r <= split_ok_nxt; out_valid_r <= out_valid_nxt;
      anc_r <= anc_nxt; far_r <= far_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; eidx_r <= eidx_nxt;
    ancx_r <= ancx_nxt; ancy_r <= ancy_nxt; farx_r <= farx_nxt; fary_r <= fary_nxt;
    pvx_r <= pvx_nxt; pvy_r <= pvy_nxt; sax_r <= sax_nxt; say_r <= say_nxt;
    sbx_r <= sbx_nxt; sby_r <= sby_nxt; fard_r <= fard_nxt; den_r <= den_nxt;
    d2_r <= d2_nxt; b2_r <= b2_nxt; f_r <= f_nxt; l_r <= l_nxt; k_r <= k_nxt;
    split_r <= split_nxt; px_r <= px_nxt; py_r <= py_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    acc_r <= acc_nxt; dot_r <= dot_nxt; c01_r <= c01_nxt; b01_r <= b01_nxt;
    lprod_r <= lprod_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt; osrc_r <= osrc_nxt;
    opass_r <= opass_nxt; oovf_r <= oovf_nxt; ofin_r <= ofin_nxt;
  end
endmodule

// File: dv/tb_top.sv
// Testbench for the closed-loop polygon simplifier: directed table plus random polygons.
`timescale 1ns / 100ps
module tb_top;
  import clps_pkg::*;

  localparam int NV = 64;
  localparam int CB = 16;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 eol;
  } vtx_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [5:0]           idx;
    logic                 passed;
    logic                 ovf;
    logic                 last;
  } kept_t;

  typedef struct {
    vtx_t        v;
    logic [16:0] cfg;
    logic        chk;
    kept_t       exp1;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  clps_in_if  #(.COORD_BITS(CB)) in_ch();
  clps_out_if #(.COORD_BITS(CB)) out_ch();

  closed_loop_polyline_simplifier_unit #(.MAX_VERTICES(NV), .COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data));

  always #2 clk = ~clk;

  int errors = 0;
  kept_t kept_q[$];
  logic [15:0] dev_limit = '0;
  longint px[NV];
  longint py[NV];
  int nloaded = 0;
  bit ovf_seen = 0;
  logic [63:0] keep;
  int anc, far_i;
  int stk_f[NV+1];
  int stk_l[NV+1];
  int stk_n;
  bit hold_off = 0;
  bit stall_on = 1;

  task automatic report(string what, kept_t got, kept_t want);
    $display("mismatch %s: got %p want %p at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit lex_lt(int i, int j);
    if (px[i] != px[j]) return px[i] < px[j];
    return py[i] < py[j];
  endfunction

  // squared distance as n0*n1/d
  function automatic void seg_dist(int p, int a, int b, output logic [63:0] n0,
                                   output logic [63:0] n1, output logic [63:0] d);
    longint ex, ey, qx, qy, den, dot, cr;
    ex = px[b] - px[a]; ey = py[b] - py[a];
    qx = px[p] - px[a]; qy = py[p] - py[a];
    den = ex * ex + ey * ey;
    dot = qx * ex + qy * ey;
    if (den == 0 || dot <= 0) begin
      n0 = qx * qx + qy * qy; n1 = 64'd1; d = 64'd1;
    end else if (dot >= den) begin
      qx = px[p] - px[b]; qy = py[p] - py[b];
      n0 = qx * qx + qy * qy; n1 = 64'd1; d = 64'd1;
    end else begin
      cr = qx * ey - qy * ex;
      if (cr < 0) cr = -cr;
      n0 = cr; n1 = cr; d = den;
    end
  endfunction

  function automatic void reduce_chain(int s, int e, int n);
    logic [63:0] b0, b1, b2, d0, d1, d2;
    logic [191:0] lhs, rhs;
    int f, l, split;
    stk_n = 0;
    if (e >= s + 2) begin
      stk_f[0] = s; stk_l[0] = e; stk_n = 1;
    end
    while (stk_n > 0) begin
      stk_n--;
      f = stk_f[stk_n]; l = stk_l[stk_n];
      b0 = 64'(dev_limit); b1 = 64'(dev_limit); b2 = 64'd1; split = -1;
      for (int k = f + 1; k < l; k++) begin
        seg_dist(k % n, f % n, l % n, d0, d1, d2);
        lhs = 192'(d0) * 192'(d1) * 192'(b2);
        rhs = 192'(b0) * 192'(b1) * 192'(d2);
        if (lhs > rhs) begin
          b0 = d0; b1 = d1; b2 = d2; split = k;
        end
      end
      if (split < 0) continue;
      keep[split % n] = 1'b1;
      if (l >= split + 2 && stk_n < NV + 1) begin
        stk_f[stk_n] = split; stk_l[stk_n] = l; stk_n++;
      end
      if (split >= f + 2 && stk_n < NV + 1) begin
        stk_f[stk_n] = f; stk_l[stk_n] = split; stk_n++;
      end
    end
  endfunction

  function automatic bit simplify(int n);
    longint best, dx, dy, d;
    int cnt;
    if (n <= 3 || dev_limit == 0) return 0;
    anc = 0;
    for (int i = 1; i < n; i++) if (lex_lt(i, anc)) anc = i;
    far_i = anc; best = -1;
    for (int i = 0; i < n; i++) begin
      dx = px[i] - px[anc]; dy = py[i] - py[anc];
      d = dx * dx + dy * dy;
      if (d > best || (d == best && lex_lt(i, far_i))) begin
        best = d; far_i = i;
      end
    end
    if (far_i == anc) return 0;
    keep = '0;
    keep[anc] = 1'b1; keep[far_i] = 1'b1;
    reduce_chain(anc, far_i > anc ? far_i : far_i + n, n);
    reduce_chain(far_i, anc > far_i ? anc : anc + n, n);
    cnt = $countones(keep);
    return cnt >= 3;
  endfunction

  function automatic void predict_vertex(vtx_t v);
    int n, total, seen, idx;
    kept_t r;
    if (nloaded < NV) begin
      px[nloaded] = v.x; py[nloaded] = v.y; nloaded++;
    end else ovf_seen = 1;
    if (!v.eol) return;
    n = nloaded;
    if (simplify(n)) begin
      total = $countones(keep); seen = 0;
      for (int i = 0; i < n; i++) begin
        idx = (anc + i) % n;
        if (keep[idx]) begin
          seen++;
          r = '{16'(px[idx]), 16'(py[idx]), 6'(idx), 1'b0, ovf_seen, seen == total};
          kept_q.push_back(r);
        end
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        r = '{16'(px[i]), 16'(py[i]), 6'(i), 1'b1, ovf_seen, i + 1 == n};
        kept_q.push_back(r);
      end
    end
    nloaded = 0; ovf_seen = 0;
  endfunction

  // receiver
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else if (stall_on) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    kept_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kept_x, out_ch.kept_y, out_ch.source_index, out_ch.passed_unchanged,
              out_ch.overflow, out_ch.final_vertex};
      if (kept_q.size() == 0) report("unexpected beat", got, got);
      else begin
        want = kept_q.pop_front();
        if (got.x !== want.x) report("kept_x", got, want);
        if (got.y !== want.y) report("kept_y", got, want);
        if (got.idx !== want.idx) report("source_index", got, want);
        if (got.passed !== want.passed) report("passed_unchanged", got, want);
        if (got.ovf !== want.ovf) report("overflow", got, want);
        if (got.last !== want.last) report("final_vertex", got, want);
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.point_x = '0; in_ch.point_y = '0; in_ch.end_of_loop = 1'b0;
  end

  task automatic send(vtx_t v);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.point_x <= v.x; in_ch.point_y <= v.y; in_ch.end_of_loop <= v.eol;
    do @(posedge clk); while (!in_ch.ready);
    predict_vertex(v);
  endtask

  task automatic idle_gap(int n);
    if (n == 0) return;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] d);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dev_limit = d;
  endtask

  function automatic logic signed [15:0] rc(int span);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic random_poly(int nv, int span, int burst_gap);
    vtx_t v;
    longint cx, cy;
    int shape;
    shape = $urandom_range(0, 3);
    cx = rc(20000); cy = rc(20000);
    for (int i = 0; i < nv; i++) begin
      if (shape == 0) begin
        v.x = 16'($urandom); v.y = 16'($urandom);
      end else if (shape == 1) begin
        v.x = 16'(cx + ((i < nv / 2) ? i * 50 : (nv - i) * 50) + rc(span));
        v.y = 16'(cy + ((i < nv / 2) ? 0 : 400) + rc(span));
      end else begin
        v.x = 16'(cx + rc(span * 20)); v.y = 16'(cy + rc(span * 20));
      end
      v.eol = (i == nv - 1);
      send(v);
      if (burst_gap && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  row_t rows[$];
  initial begin
    vtx_t v;
    row_t r;
    logic [15:0] devs[5];
    devs = '{16'd0, 16'd1, 16'd65535, 16'd37, 16'd500};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: pass-through triangle, extremes, square with a dent, coincident points
    rows.push_back('{'{16'sh8000, 16'sh7fff, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sh8000, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sh0000, 16'shffff, 1'b1}, 17'h0_0000, 1'b1,
                     '{16'sh0000, 16'shffff, 6'd2, 1'b1, 1'b0, 1'b1}});
    rows.push_back('{'{16'sd0, 16'sd0, 1'b0}, 17'h1_0002, 1'b0, '0});
    rows.push_back('{'{16'sd100, 16'sd0, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd101, 16'sd50, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd100, 16'sd100, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd100, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd50, 16'sd80, 1'b1}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd5, 16'sd5, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd5, 16'sd5, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd5, 16'sd5, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sd5, 16'sd5, 1'b1}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sh8000, 16'sh8000, 1'b0}, 17'h1_ffff, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sh8000, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sh7fff, 1'b0}, 17'h0_0000, 1'b0, '0});
    rows.push_back('{'{16'sh8000, 16'sh7fff, 1'b1}, 17'h0_0000, 1'b0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      if (r.cfg[16]) set_limit(r.cfg[15:0]);
      send(r.v);
      if (r.chk && kept_q[$] !== r.exp1) begin
        report("table row", kept_q[$], r.exp1);
      end
    end
    set_limit(16'd1);
    // overflow: 66 vertices, last dropped final still starts the run
    for (int i = 0; i < 66; i++) begin
      v.x = 16'(i * 97); v.y = 16'((i % 3) * 40); v.eol = (i == 65);
      send(v);
    end
    // long receiver hold-off while vertices keep coming
    drain();
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        random_poly(5, 30, 0);
        random_poly(6, 30, 0);
      end
    join
    // random polygons across several limits
    for (int p = 0; p < 18; p++) begin
      if (p % 4 == 0) begin
        set_limit(devs[(p / 4) % 5]);
        stall_on = (p % 8 == 0) ? 1'b0 : 1'b1;
      end
      if (p == 9) random_poly(NV, 40, 1);
      else random_poly($urandom_range(1, 10), $urandom_range(0, 300), 1);
    end
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end
endmodule
